// File: rtl/sem_pkg.sv
package sem_pkg;

   localparam int PIX_W = 8;
   localparam int VAL_W = 12;
   localparam int NUM_W = 19;
   localparam int DEN_W = 11;
   localparam int Q_W   = 8;
   localparam int CSR_W = 10;
   localparam int CSR_AW = 2;

   localparam logic [CSR_AW-1:0] CSR_IMAGE_ROWS    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_COLS    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_KERNEL_SELECT = 2'd2;

   localparam logic [CSR_W-1:0] ROWS_RESET = 10'd512;
   localparam logic [CSR_W-1:0] COLS_RESET = 10'd512;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic KERNEL_VERTICAL = 1'b0;

   typedef struct packed {
      logic             cmd;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last_out;
   } rsp_type;

   typedef enum logic {
      OP_PUSH,
      OP_PULL
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [PIX_W-1:0] pixel;
   } item_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_PUSH,
      B_NORM,
      B_DIV
   } back_state_type;

endpackage

// File: rtl/sem_front.sv
module sem_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sem_pkg::req_type  req_data,
   output logic              busy,
   output sem_pkg::item_type q_item,
   output logic              q_valid,
   input  logic              q_pop
);
   import sem_pkg::*;

   localparam int DEPTH = 4;
   localparam int PW = $clog2(DEPTH);

   item_type       queue_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PW:0]    count_ff, count_in;
   logic           push;
   item_type       item;

   assign busy    = (count_ff == (PW+1)'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = queue_ff[rd_ptr_ff];
   assign push    = start && !busy;

   always_comb begin
      item.op    = (req_data.cmd == CMD_PUSH) ? OP_PUSH : OP_PULL;
      item.pixel = req_data.pixel_in;
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (PW+1)'(push) - (PW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(DEPTH))
      else $error("queue overfilled");

endmodule

// File: rtl/sem_div.sv
module sem_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      div_start,
   input  logic [sem_pkg::NUM_W-1:0] num,
   input  logic [sem_pkg::DEN_W-1:0] den,
   output logic                      div_done,
   output logic [sem_pkg::Q_W-1:0]   quot
);
   import sem_pkg::*;

   localparam int CW = $clog2(Q_W);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CW-1:0]    step_ff, step_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             ge;

   assign div_done = done_ff;
   assign quot     = q_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      ge      = (rem_ff >= dsh_ff);
      if (div_start) begin
         rem_in  = num;
         dsh_in  = NUM_W'(den) << (Q_W - 1);
         q_in    = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         q_in   = {q_ff[Q_W-2:0], ge};
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(Q_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule

// File: rtl/sem_back.sv
module sem_back #(
   parameter int MAX_DIM = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sem_pkg::item_type          q_item,
   input  logic                       q_valid,
   output logic                       q_pop,
   input  logic                       csr_we,
   input  logic [sem_pkg::CSR_AW-1:0] csr_addr,
   input  logic [sem_pkg::CSR_W-1:0]  csr_wdata,
   output logic                       rsp_valid,
   output sem_pkg::rsp_type           rsp_data
);
   import sem_pkg::*;

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int AW = $clog2(MAX_DIM);
   localparam int FW = $clog2(MAX_DIM * MAX_DIM);
   localparam int FDEPTH = MAX_DIM * MAX_DIM;

   logic [2*PIX_W-1:0] line_mem [MAX_DIM];
   logic [VAL_W-1:0]   filt_mem [FDEPTH];

   back_state_type     state_ff, state_in;
   logic               phase_ff, phase_in;
   logic [DW-1:0]      row_ff, row_in;
   logic [DW-1:0]      col_ff, col_in;
   logic [FW-1:0]      cnt_ff, cnt_in;
   logic [FW-1:0]      rd_idx_ff, rd_idx_in;
   logic [FW-1:0]      total_ff, total_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic signed [VAL_W-1:0] max_ff, max_in;
   logic [CSR_W-1:0]   rows_ff, rows_in;
   logic [CSR_W-1:0]   cols_ff, cols_in;
   logic               ks_ff, ks_in;
   logic [PIX_W-1:0]   win_ff [3][3];
   logic [PIX_W-1:0]   nw [3][3];
   logic [PIX_W-1:0]   cur_px_ff;
   logic [2*PIX_W-1:0] line_rd_ff;
   logic [VAL_W-1:0]   filt_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               line_re, line_we, filt_re, filt_we, shift_en;
   logic [DW-1:0]      rows_c, cols_c;
   logic [2*DW-1:0]    prod;
   logic signed [VAL_W-1:0] acc, pos, neg;
   logic [VAL_W-1:0]   diff, den_full;
   logic [NUM_W-1:0]   num;
   logic               div_start, div_done;
   logic [Q_W-1:0]     quot;
   logic [FW:0]        idx_next;
   logic               last;

   sem_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .num       (num),
      .den       (den_full[DEN_W-1:0]),
      .div_done  (div_done),
      .quot      (quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (rows_ff < 10'd3) rows_c = DW'(3);
      else if (32'(rows_ff) > MAX_DIM) rows_c = DW'(MAX_DIM);
      else rows_c = DW'(rows_ff);
      if (cols_ff < 10'd3) cols_c = DW'(3);
      else if (32'(cols_ff) > MAX_DIM) cols_c = DW'(MAX_DIM);
      else cols_c = DW'(cols_ff);
      prod     = (2*DW)'(rows_c - DW'(2)) * (2*DW)'(cols_c - DW'(2));
      total_in = prod[FW-1:0];
   end

   // window after shifting in the new column
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nw[k][0] = win_ff[k][1];
         nw[k][1] = win_ff[k][2];
      end
      nw[0][2] = line_rd_ff[2*PIX_W-1:PIX_W];
      nw[1][2] = line_rd_ff[PIX_W-1:0];
      nw[2][2] = cur_px_ff;
      if (ks_ff == KERNEL_VERTICAL) begin
         pos = VAL_W'(nw[0][2]) + (VAL_W'(nw[1][2]) << 1) + VAL_W'(nw[2][2]);
         neg = VAL_W'(nw[0][0]) + (VAL_W'(nw[1][0]) << 1) + VAL_W'(nw[2][0]);
      end else begin
         pos = VAL_W'(nw[2][0]) + (VAL_W'(nw[2][1]) << 1) + VAL_W'(nw[2][2]);
         neg = VAL_W'(nw[0][0]) + (VAL_W'(nw[0][1]) << 1) + VAL_W'(nw[0][2]);
      end
      acc = pos - neg;
   end

   always_comb begin
      diff     = filt_rd_ff - min_ff;
      den_full = max_ff - min_ff;
      num      = (NUM_W'(diff) << 8) - NUM_W'(diff);
      idx_next = (FW+1)'(rd_idx_ff) + 1'b1;
      last     = (idx_next >= (FW+1)'(total_ff));
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      ks_in        = ks_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      line_re      = 1'b0;
      line_we      = 1'b0;
      filt_re      = 1'b0;
      filt_we      = 1'b0;
      shift_en     = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == OP_PUSH && !phase_ff) begin
                  line_re  = 1'b1;
                  state_in = B_PUSH;
               end else if (q_item.op == OP_PULL && phase_ff) begin
                  filt_re  = 1'b1;
                  state_in = B_NORM;
               end
            end
         end
         B_PUSH: begin
            line_we  = 1'b1;
            shift_en = 1'b1;
            if (row_ff >= DW'(2) && col_ff >= DW'(2)) begin
               filt_we = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == '0) begin
                  min_in = acc;
                  max_in = acc;
               end else begin
                  if (acc < min_ff) min_in = acc;
                  if (acc > max_ff) max_in = acc;
               end
            end
            if (col_ff + 1'b1 >= cols_c) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
               if (row_ff + 1'b1 >= rows_c) begin
                  phase_in  = 1'b1;
                  rd_idx_in = '0;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
            state_in = B_IDLE;
         end
         B_NORM: begin
            if (den_full == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.pixel_out = '0;
               rsp_data_in.last_out  = last;
               state_in = B_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = B_DIV;
            end
         end
         B_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.pixel_out = quot;
               rsp_data_in.last_out  = last;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (rsp_valid_in) begin
         if (last) begin
            phase_in  = 1'b0;
            row_in    = '0;
            col_in    = '0;
            cnt_in    = '0;
            rd_idx_in = '0;
         end else begin
            rd_idx_in = idx_next[FW-1:0];
         end
      end
      if (csr_we && (csr_addr == CSR_IMAGE_ROWS || csr_addr == CSR_IMAGE_COLS ||
                     csr_addr == CSR_KERNEL_SELECT)) begin
         case (csr_addr)
            CSR_IMAGE_ROWS: rows_in = csr_wdata;
            CSR_IMAGE_COLS: cols_in = csr_wdata;
            default:        ks_in   = csr_wdata[0];
         endcase
         phase_in  = 1'b0;
         row_in    = '0;
         col_in    = '0;
         cnt_in    = '0;
         rd_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (line_re) line_rd_ff <= line_mem[col_ff[AW-1:0]];
      if (line_we) line_mem[col_ff[AW-1:0]] <= {line_rd_ff[PIX_W-1:0], cur_px_ff};
      if (filt_re) filt_rd_ff <= filt_mem[rd_idx_ff];
      if (filt_we) filt_mem[cnt_ff] <= acc;
   end

   always_ff @(posedge clock) begin
      if (line_re) cur_px_ff <= q_item.pixel;
      if (shift_en) begin
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               win_ff[k][m] <= nw[k][m];
            end
         end
      end
      rsp_data_ff <= rsp_data_in;
      total_ff    <= total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         phase_ff     <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         ks_ff        <= KERNEL_VERTICAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         ks_ff        <= ks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == B_NORM || state_ff == B_DIV))
      else $error("result without a pull in progress");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == B_DIV)
      else $error("divider finished outside divide state");

   assert property (@(posedge clock) disable iff (reset)
      !phase_ff |-> rd_idx_ff == '0)
      else $error("readout index moved while loading");

endmodule

// File: rtl/sobel_edge_minmax_normalize.sv
// Push: accepted into a 4-entry queue, then handled in B_PUSH after it leaves the queue.
// Pull: after the item leaves the queue, B_NORM strobes 0 for a flat frame or starts
// the 8-step shift-subtract divider, and B_DIV strobes its quotient; one pull at a time.
// busy is high only while the queue is full; results cannot be stalled.
// Synchronous reset: frame restarts at row 0, registers at 512/512/vertical.
module sobel_edge_minmax_normalize #(
   parameter int MAX_DIM = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  sem_pkg::req_type           req_data,
   output logic                       busy,
   output logic                       rsp_valid,
   output sem_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [sem_pkg::CSR_AW-1:0] csr_addr,
   input  logic [sem_pkg::CSR_W-1:0]  csr_wdata
);
   import sem_pkg::*;

   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   sem_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   sem_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
